// File: rtl/core/mexp_pkg.sv
package mexp_pkg;

  // Width of the base, the exponent, the modulus and the result
  localparam int unsigned ValueWidth = 31;
  // Bits of a bit counter that walks ValueWidth positions
  localparam int unsigned CntWidth = $clog2(ValueWidth);
  // Modulus after reset: ten to the ninth plus seven
  localparam logic [ValueWidth-1:0] ModulusReset = ValueWidth'(1000000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_SQR,
    ST_MUL
  } mexp_state_e;

endpackage

// File: rtl/core/modular_exponentiation.sv
// Modular exponentiation, base to the power exponent modulo a modulus register.
//
// Request channel: base_i and exponent_i are taken at a rising edge at which start
// is high and busy is low. busy stays high while a request is being worked on.
// Result channel: power_mod_o is valid for exactly one cycle, marked by
// result_valid_o. The receiver cannot stall, so it must take the result then.
// Configuration: cfg_we_i writes cfg_wdata_i into the modulus register; write it
// only while busy is low and no result is pending.
//
// A zero exponent or a modulus below two is answered in the next cycle. Otherwise
// the shared modular multiply-add unit, which takes one multiplier bit per cycle,
// first reduces the base, then runs one square for every exponent bit and, on a
// one bit, one multiply by the base.
// A new request may be taken in the cycle that shows the previous result.
// Reset clears the sequencer and the strobe and restores the modulus to its
// default of 1000000007; no request is in flight afterwards.
module modular_exponentiation import mexp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] base_i,
  input  logic [ValueWidth-1:0] exponent_i,
  input  logic                  cfg_we_i,
  input  logic [ValueWidth-1:0] cfg_wdata_i,
  output logic                  result_valid_o,
  output logic [ValueWidth-1:0] power_mod_o
);

  localparam logic [CntWidth-1:0] LastBit = CntWidth'(ValueWidth - 1);

  // One step of interleaved modular multiplication: (2r + bit*a) mod m, for r, a < m.
  // The sum stays below 3m, so three candidates are formed side by side.
  function automatic logic [ValueWidth-1:0] mod_step(
    input logic [ValueWidth-1:0] r,
    input logic [ValueWidth-1:0] a,
    input logic                  b,
    input logic [ValueWidth-1:0] m
  );
    logic [ValueWidth+2:0] s;
    logic [ValueWidth+2:0] s1;
    logic [ValueWidth+2:0] s2;
    s  = {2'b00, r, 1'b0} + (b ? {3'b000, a} : '0);
    s1 = s - {3'b000, m};
    s2 = s - {2'b00, m, 1'b0};
    if (!s2[ValueWidth+2]) begin
      mod_step = s2[ValueWidth-1:0];
    end else if (!s1[ValueWidth+2]) begin
      mod_step = s1[ValueWidth-1:0];
    end else begin
      mod_step = s[ValueWidth-1:0];
    end
  endfunction

  mexp_state_e state_q, state_d;

  logic [ValueWidth-1:0] mod_q;
  logic [ValueWidth-1:0] base_q, base_d;   // reduced base
  logic [ValueWidth-1:0] exp_q, exp_d;     // exponent, MSB is the current bit
  logic [ValueWidth-1:0] acc_q, acc_d;     // running power
  logic [ValueWidth-1:0] r_q, r_d;         // partial product of the unit
  logic [ValueWidth-1:0] opa_q, opa_d;     // multiplicand
  logic [ValueWidth-1:0] opb_q, opb_d;     // multiplier, MSB first
  logic [CntWidth-1:0]   bit_q, bit_d;     // multiplier bits left, minus one
  logic [CntWidth-1:0]   ebit_q, ebit_d;   // exponent bits left, minus one
  logic                  valid_q, valid_d;
  logic [ValueWidth-1:0] res_q, res_d;

  logic                  req_acc;
  logic [ValueWidth-1:0] step_res;
  logic                  unit_last;
  logic                  exp_last;

  assign req_acc   = start && !busy;
  assign step_res  = mod_step(r_q, opa_q, opb_q[ValueWidth-1], mod_q);
  assign unit_last = (bit_q == '0);
  assign exp_last  = (ebit_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc && (mod_q > ValueWidth'(1)) && (exponent_i != '0)) begin
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (unit_last) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (unit_last) begin
          if (exp_q[ValueWidth-1]) begin
            state_d = ST_MUL;
          end else if (exp_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        if (unit_last) begin
          state_d = exp_last ? ST_IDLE : ST_SQR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    base_d  = base_q;
    exp_d   = exp_q;
    acc_d   = acc_q;
    r_d     = r_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    bit_d   = bit_q;
    ebit_d  = ebit_q;
    valid_d = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (mod_q < ValueWidth'(2)) begin
            valid_d = 1'b1;
            res_d   = '0;
          end else if (exponent_i == '0) begin
            valid_d = 1'b1;
            res_d   = ValueWidth'(1);
          end else begin
            // Reduce the base as 1 * base mod m
            exp_d  = exponent_i;
            acc_d  = ValueWidth'(1);
            r_d    = '0;
            opa_d  = ValueWidth'(1);
            opb_d  = base_i;
            bit_d  = LastBit;
            ebit_d = LastBit;
          end
        end
      end
      ST_RED, ST_SQR, ST_MUL: begin
        // Advance the unit by one multiplier bit
        r_d   = step_res;
        opb_d = {opb_q[ValueWidth-2:0], 1'b0};
        bit_d = bit_q - CntWidth'(1);
        if (unit_last) begin
          r_d   = '0;
          bit_d = LastBit;
          if (state_q == ST_RED) begin
            base_d = step_res;
            opa_d  = acc_q;
            opb_d  = acc_q;
          end else begin
            acc_d = step_res;
            if ((state_q == ST_SQR) && exp_q[ValueWidth-1]) begin
              opa_d = base_q;
              opb_d = step_res;
            end else begin
              // Exponent bit done: drop it and square again, or deliver
              exp_d  = {exp_q[ValueWidth-2:0], 1'b0};
              ebit_d = ebit_q - CntWidth'(1);
              opa_d  = step_res;
              opb_d  = step_res;
              if (exp_last) begin
                valid_d = 1'b1;
                res_d   = step_res;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      mod_q   <= ModulusReset;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    bit_q  <= bit_d;
    ebit_q <= ebit_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign power_mod_o    = res_q;

  // An accepted request is either in flight or answered in the next cycle
  a_req_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (busy || result_valid_o))
    else $error("request neither in flight nor answered");

  // A result only follows a request or a running computation
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy || start))
    else $error("result without request");

  // A multiply by the base only follows a square or continues itself
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> ($past(state_q) == ST_MUL || $past(state_q) == ST_SQR))
    else $error("multiply entered out of order");

  // The base reduction always runs a full multiplier word before squaring
  a_red_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED && !unit_last) |=> (state_q == ST_RED))
    else $error("base reduction left early");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Testbench for the modular exponentiation block.
// Requests go in on the start/busy handshake, each one with its own power_mod
// worked out up front by a square-and-multiply predictor. The predictor runs
// against a shadow copy of the modulus register. Every strobed result is checked
// against the oldest waiting prediction.
module tb;
  import mexp_pkg::*;

  typedef logic [ValueWidth-1:0] value_t;

  localparam value_t AllOnes = {ValueWidth{1'b1}};
  // Cycle bound for the whole run, and the length of the final watch for stray strobes
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned TailCycles = 2100;

  logic   clk_i;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  value_t base_i = '0;
  value_t exponent_i = '0;
  logic   cfg_we_i = 1'b0;
  value_t cfg_wdata_i = '0;
  logic   result_valid_o;
  value_t power_mod_o;

  value_t pending_power_mod[$];
  value_t modulus_shadow = ModulusReset;
  int     mismatch_count = 0;
  int     cycle_count = 0;

  modular_exponentiation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .base_i        (base_i),
    .exponent_i    (exponent_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .power_mod_o   (power_mod_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Square and multiply over every exponent bit, MSB first. Operands stay below
  // 2^31, so a 64-bit product never overflows before the reduction.
  function automatic value_t predict_power_mod(value_t base, value_t exponent,
                                               value_t modulus);
    longint unsigned m;
    longint unsigned b;
    longint unsigned acc;
    m = modulus;
    if (m < 2) begin
      return '0;
    end
    if (exponent == '0) begin
      return value_t'(1);
    end
    b = longint'(base) % m;
    acc = 1;
    for (int i = ValueWidth - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (exponent[i]) begin
        acc = (acc * b) % m;
      end
    end
    return value_t'(acc);
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 6);
    end
    return $urandom_range(20, 200);
  endfunction

  // Raise start with the operands, hold until the request is taken, then book
  // the prediction. busy is sampled as it stood before the edge.
  task automatic send_request(value_t base, value_t exponent);
    int unsigned gap;
    start      <= 1'b1;
    base_i     <= base;
    exponent_i <= exponent;
    do begin
      @(posedge clk_i);
    end while (busy);
    pending_power_mod.push_back(predict_power_mod(base, exponent, modulus_shadow));
    gap = pick_gap();
    // Keep start high when the next request follows straight away
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold until every booked result has come back
  task automatic settle_idle();
    start <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_power_mod.size() != 0 || busy);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the modulus only with the block idle; the shadow follows at the same edge
  task automatic write_modulus(value_t value);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    modulus_shadow = value;
  endtask

  task automatic test_default_modulus();
    // Zero exponent, zero base, unit base
    send_request('0, '0);
    send_request('0, value_t'(5));
    send_request(value_t'(1), AllOnes);
    send_request(AllOnes, '0);
    send_request(AllOnes, AllOnes);
    send_request(value_t'(2), value_t'(30));
    send_request(value_t'(12345), value_t'(1));
    // Bases at and just above the modulus fold back in the base reduction
    send_request(ModulusReset, value_t'(3));
    send_request(ModulusReset + value_t'(1), value_t'(1));
    send_request(value_t'(31'h5555_5555), value_t'(31'h2AAA_AAAA));
    send_request(value_t'(31'h2AAA_AAAA), value_t'(31'h5555_5555));
  endtask

  task automatic test_operand_extremes();
    write_modulus(AllOnes);
    send_request(AllOnes, value_t'(5));
    send_request(AllOnes - value_t'(1), AllOnes);
    send_request(value_t'(3), AllOnes);
    write_modulus(value_t'(2));
    send_request(value_t'(3), value_t'(7));
    send_request(value_t'(4), '0);
    send_request(AllOnes, AllOnes);
  endtask

  // A modulus of one or zero gives zero whatever the operands
  task automatic test_degenerate_moduli();
    write_modulus(value_t'(1));
    send_request(value_t'(5), value_t'(3));
    send_request(value_t'(5), '0);
    write_modulus('0);
    send_request(value_t'(7), '0);
    send_request(AllOnes, AllOnes);
  endtask

  // Burst of five requests, full drain, then another burst of five
  task automatic test_drain_pause();
    write_modulus(ModulusReset);
    for (int i = 0; i < 5; i++) begin
      send_request(value_t'($urandom), value_t'($urandom));
    end
    settle_idle();
    for (int i = 0; i < 5; i++) begin
      send_request(value_t'($urandom), value_t'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    value_t modulus;
    value_t base;
    value_t exponent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       modulus = value_t'($urandom);
        1:       modulus = value_t'($urandom_range(2, 255));
        2:       modulus = AllOnes;
        3:       modulus = value_t'($urandom) | value_t'(1 << (ValueWidth - 1));
        4:       modulus = value_t'($urandom_range(0, 1));
        default: modulus = value_t'($urandom_range(2, 65535));
      endcase
      write_modulus(modulus);
      for (int i = 0; i < 44; i++) begin
        case ($urandom_range(0, 9))
          6:       base = value_t'($urandom_range(0, 16));
          7:       base = value_t'(longint'(modulus) + $urandom_range(0, 2) - 1);
          8:       base = AllOnes;
          9:       base = '0;
          default: base = value_t'($urandom);
        endcase
        case ($urandom_range(0, 9))
          6:       exponent = '0;
          7:       exponent = value_t'($urandom_range(1, 8));
          8:       exponent = AllOnes;
          9:       exponent = value_t'(1) << $urandom_range(0, ValueWidth - 1);
          default: exponent = value_t'($urandom);
        endcase
        send_request(base, exponent);
        // Now and then let the pipeline run dry mid-phase
        if ($urandom_range(0, 29) == 0) begin
          settle_idle();
        end
      end
    end
  endtask

  // Results cannot be held off: take each strobe at the edge that ends it
  always @(posedge clk_i) begin
    value_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_power_mod.size() == 0) begin
        $error("power_mod: unexpected result %0d with nothing pending", power_mod_o);
        mismatch_count++;
      end else begin
        want = pending_power_mod.pop_front();
        if (power_mod_o !== want) begin
          $error("power_mod: expected %0d, actual %0d", want, power_mod_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_modulus();
    test_operand_extremes();
    test_degenerate_moduli();
    test_drain_pause();
    test_random_traffic();

    // Drain, then watch a while longer for stray strobes
    settle_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_power_mod.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
